// File: src/asvs_pkg.sv
`timescale 1ns / 1ps

package asvs_pkg;

    localparam int WINDOW_MAX_DEF = 20;
    localparam int FULL_SCALE     = 4096;

    localparam int CODE_W = 12;
    localparam int MV_W   = 16;
    localparam int NUM_W  = 29;
    localparam int DEN_W  = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VREF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES_TOP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RES_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_MOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 3'd6;

    localparam logic [1:0] SMOOTH_OFF  = 2'd0;
    localparam logic [1:0] SMOOTH_ROLL = 2'd1;
    localparam logic [1:0] SMOOTH_EMA  = 2'd2;

    localparam logic [12:0] VREF_MIN = 13'd2700;
    localparam logic [12:0] VREF_MAX = 13'd5500;
    localparam logic [12:0] VREF_RST = 13'd4096;
    localparam logic [15:0] RES_RST  = 16'd10000;
    localparam logic [8:0]  ALPHA_RST = 9'd128;
    localparam logic [8:0]  ALPHA_ONE = 9'd256;
    localparam logic [4:0]  WLEN_RST = 5'd10;

    localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;

    function automatic logic [MV_W-1:0] sat16(input logic [NUM_W-1:0] v);
        logic [MV_W-1:0] r;
        r = (v > NUM_W'(MV_MAX)) ? MV_MAX : v[MV_W-1:0];
        return r;
    endfunction

endpackage

// File: src/asvs_div.sv
`timescale 1ns / 1ps

module asvs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [asvs_pkg::NUM_W-1:0]    i_num,
    input  logic [asvs_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [asvs_pkg::NUM_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(asvs_pkg::NUM_W + 1);

    logic [CNT_W-1:0]             r_cnt;
    logic                         r_done;
    logic [asvs_pkg::NUM_W-1:0]   r_q;
    logic [asvs_pkg::DEN_W-1:0]   r_rem;
    logic [asvs_pkg::DEN_W-1:0]   r_den;
    logic [asvs_pkg::DEN_W:0]     n_trial;
    logic                         n_fit;

    assign n_trial = {r_rem, r_q[asvs_pkg::NUM_W-1]};
    assign n_fit   = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(asvs_pkg::NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[asvs_pkg::NUM_W-2:0], n_fit};
            if (n_fit) begin
                r_rem <= asvs_pkg::DEN_W'(n_trial - {1'b0, r_den});
            end else begin
                r_rem <= n_trial[asvs_pkg::DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/adc_smoothing_voltage_scaler.sv
`timescale 1ns / 1ps
// Flow: direct scaling goes accept, S_SCALE, S_DWAIT, S_OUT; divider scaling adds S_DGO
// and the bit-serial divider. EMA adds S_EMA1 on its first item, S_EMA1 and S_EMA2 after.
// Rolling mean adds a second division through S_RD, S_UPD, S_AVG and S_DGO, or a fill of
// the whole window through S_FILL on the first item after reset or a window change.
// One item at a time: a new sample is taken only in S_IDLE; a stalled result holds the next item.
// Reset: synchronous, active low; registers take their reset values, no clearing pass.
module adc_smoothing_voltage_scaler #(
    parameter int WINDOW_MAX = asvs_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,  // [11:0] sample_code
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [15:0]                       o_m_axis_tdata,  // [15:0] millivolts
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [asvs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [asvs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = asvs_pkg::MV_W + $clog2(WINDOW_MAX);
    localparam int FS_SH = $clog2(asvs_pkg::FULL_SCALE);
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_EMA1  = 4'd1;
    localparam logic [ST_W-1:0] S_EMA2  = 4'd2;
    localparam logic [ST_W-1:0] S_SCALE = 4'd3;
    localparam logic [ST_W-1:0] S_DGO   = 4'd4;
    localparam logic [ST_W-1:0] S_DWAIT = 4'd5;
    localparam logic [ST_W-1:0] S_FILL  = 4'd6;
    localparam logic [ST_W-1:0] S_RD    = 4'd7;
    localparam logic [ST_W-1:0] S_UPD   = 4'd8;
    localparam logic [ST_W-1:0] S_AVG   = 4'd9;
    localparam logic [ST_W-1:0] S_OUT   = 4'd10;

    logic [12:0] r_vref;
    logic [15:0] r_res_top;
    logic [15:0] r_res_bot;
    logic [8:0]  r_alpha;
    logic [4:0]  r_wlen;
    logic        r_div_mode;
    logic [1:0]  r_smooth;

    logic [ST_W-1:0]                  r_state;
    logic                             r_phase;
    logic                             r_byp;
    logic [asvs_pkg::CODE_W-1:0]      r_code;
    logic [asvs_pkg::CODE_W-1:0]      r_ema;
    logic                             r_ema_primed;
    logic [19:0]                      r_prod;
    logic [asvs_pkg::NUM_W-1:0]       r_num;
    logic [asvs_pkg::DEN_W-1:0]       r_den;
    logic [asvs_pkg::MV_W-1:0]        r_v;
    logic [asvs_pkg::MV_W-1:0]        r_res;
    logic [asvs_pkg::MV_W-1:0]        r_rd;
    logic [IDX_W-1:0]                 r_wslot;
    logic [SUM_W-1:0]                 r_sum;
    logic                             r_wprimed;
    logic                             r_out_valid;
    logic [asvs_pkg::MV_W-1:0]        r_out;
    logic [asvs_pkg::MV_W-1:0]        r_win [WINDOW_MAX];

    logic [LEN_W-1:0]             n_len;
    logic [8:0]                   n_alpha;
    logic [12:0]                  n_vref;
    logic [20:0]                  n_ema_sum;
    logic [asvs_pkg::NUM_W-1:0]   n_scale_num;
    logic [asvs_pkg::DEN_W-1:0]   n_scale_den;
    logic [IDX_W-1:0]             n_slot_next;
    logic                         n_slot_wrap;
    logic                         n_in_acc;
    logic                         n_cfg_acc;
    logic                         n_div_done;
    logic [asvs_pkg::NUM_W-1:0]   n_quot;
    logic [asvs_pkg::MV_W-1:0]    n_quot_sat;
    logic                         n_out_free;
    logic                         n_win_we;

    assign n_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign n_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign n_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        if (r_wlen == 5'd0) begin
            n_len = LEN_W'(1);
        end else if (32'(r_wlen) > WINDOW_MAX) begin
            n_len = LEN_W'(WINDOW_MAX);
        end else begin
            n_len = LEN_W'(r_wlen);
        end

        if (r_alpha == 9'd0) begin
            n_alpha = 9'd1;
        end else if (r_alpha > asvs_pkg::ALPHA_ONE) begin
            n_alpha = asvs_pkg::ALPHA_ONE;
        end else begin
            n_alpha = r_alpha;
        end

        if (r_vref < asvs_pkg::VREF_MIN) begin
            n_vref = asvs_pkg::VREF_MIN;
        end else if (r_vref > asvs_pkg::VREF_MAX) begin
            n_vref = asvs_pkg::VREF_MAX;
        end else begin
            n_vref = r_vref;
        end

        n_ema_sum = 21'(r_prod) + 21'((asvs_pkg::ALPHA_ONE - n_alpha) * r_ema);

        if (r_div_mode) begin
            n_scale_num = asvs_pkg::NUM_W'(r_code * (17'(r_res_top) + 17'(r_res_bot)));
            n_scale_den = asvs_pkg::DEN_W'(r_res_bot);
        end else begin
            n_scale_num = (asvs_pkg::NUM_W'(n_vref * r_code)
                        + asvs_pkg::NUM_W'(asvs_pkg::FULL_SCALE / 2)) >> FS_SH;
            n_scale_den = asvs_pkg::DEN_W'(asvs_pkg::FULL_SCALE);
        end

        n_slot_wrap = (LEN_W'(r_wslot) + LEN_W'(1) >= n_len);
        n_slot_next = n_slot_wrap ? '0 : r_wslot + 1'b1;
        n_quot_sat  = asvs_pkg::sat16(r_byp ? r_num : n_quot);
        n_win_we    = (r_state == S_FILL) || (r_state == S_UPD);
    end

    asvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DGO),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    always_ff @(posedge i_clk) begin
        if (n_win_we) begin
            r_win[r_wslot] <= r_v;
        end
        if (r_state == S_RD) begin
            r_rd <= r_win[r_wslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref       <= asvs_pkg::VREF_RST;
            r_res_top    <= asvs_pkg::RES_RST;
            r_res_bot    <= asvs_pkg::RES_RST;
            r_alpha      <= asvs_pkg::ALPHA_RST;
            r_wlen       <= asvs_pkg::WLEN_RST;
            r_div_mode   <= 1'b0;
            r_smooth     <= asvs_pkg::SMOOTH_OFF;
            r_state      <= S_IDLE;
            r_phase      <= 1'b0;
            r_ema        <= '0;
            r_ema_primed <= 1'b0;
            r_wslot      <= '0;
            r_sum        <= '0;
            r_wprimed    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_OUT && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_code  <= i_s_axis_tdata[asvs_pkg::CODE_W-1:0];
                        r_phase <= 1'b0;
                        r_state <= (r_smooth == asvs_pkg::SMOOTH_EMA) ? S_EMA1 : S_SCALE;
                    end
                end
                S_EMA1: begin
                    if (!r_ema_primed) begin
                        r_ema        <= r_code;
                        r_ema_primed <= 1'b1;
                        r_state      <= S_SCALE;
                    end else begin
                        r_prod  <= 20'(n_alpha * r_code);
                        r_state <= S_EMA2;
                    end
                end
                S_EMA2: begin
                    r_ema   <= n_ema_sum[19:8];
                    r_code  <= n_ema_sum[19:8];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_num   <= n_scale_num;
                    r_den   <= n_scale_den;
                    r_byp   <= !r_div_mode;
                    r_state <= r_div_mode ? S_DGO : S_DWAIT;
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (n_div_done || r_byp) begin
                        if (r_phase || r_smooth != asvs_pkg::SMOOTH_ROLL) begin
                            r_res   <= n_quot_sat;
                            r_state <= S_OUT;
                        end else if (!r_wprimed) begin
                            r_v     <= n_quot_sat;
                            r_wslot <= '0;
                            r_sum   <= '0;
                            r_state <= S_FILL;
                        end else begin
                            r_v <= n_quot_sat;
                            if (LEN_W'(r_wslot) >= n_len) begin
                                r_wslot <= '0;
                            end
                            r_state <= S_RD;
                        end
                    end
                end
                S_FILL: begin
                    r_sum <= r_sum + SUM_W'(r_v);
                    if (LEN_W'(r_wslot) == n_len - LEN_W'(1)) begin
                        r_wslot   <= '0;
                        r_wprimed <= 1'b1;
                        r_state   <= S_AVG;
                    end else begin
                        r_wslot <= r_wslot + 1'b1;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum   <= r_sum - SUM_W'(r_rd) + SUM_W'(r_v);
                    r_wslot <= n_slot_next;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_num   <= asvs_pkg::NUM_W'(r_sum) + asvs_pkg::NUM_W'(n_len >> 1);
                    r_den   <= asvs_pkg::DEN_W'(n_len);
                    r_byp   <= 1'b0;
                    r_phase <= 1'b1;
                    r_state <= S_DGO;
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (n_cfg_acc) begin
                case (i_cfg_index)
                    asvs_pkg::REG_VREF:    r_vref     <= i_cfg_data[12:0];
                    asvs_pkg::REG_RES_TOP: r_res_top  <= i_cfg_data;
                    asvs_pkg::REG_RES_BOT: r_res_bot  <= i_cfg_data;
                    asvs_pkg::REG_ALPHA:   r_alpha    <= i_cfg_data[8:0];
                    asvs_pkg::REG_WIN_LEN: begin
                        r_wlen    <= i_cfg_data[4:0];
                        r_wslot   <= '0;
                        r_sum     <= '0;
                        r_wprimed <= 1'b0;
                    end
                    asvs_pkg::REG_DIV_MOD: r_div_mode <= i_cfg_data[0];
                    asvs_pkg::REG_SMOOTH:  r_smooth   <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
    assign o_cfg_ready     = (r_state == S_IDLE);

endmodule
